// ----- rtl/core/gps_pkg.sv -----
// Shared types, constants and helpers for the Gaussian polar sampler.
// No dependencies; every other file in rtl/core uses this package.
`timescale 1ns / 1ps

package gps_pkg;

  localparam int UNIFORM_BITS = 16;

  localparam int LOG_STEPS   = 28;
  localparam int DIV_BITS    = 64;
  localparam int SQRT_STEPS  = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [29:0] LN2_Q30         = 30'd744261118;
  localparam logic [31:0] TRUNC_LIMIT_Q12 = 32'd4823;
  localparam logic [31:0] ONE_Q30         = 32'h4000_0000;

  typedef enum logic [1:0] {
    REG_TRUNCATE_MODE = 2'd0,
    REG_MEAN_OFFSET   = 2'd1,
    REG_SIGMA_SCALE   = 2'd2
  } cfg_reg_t;

  // Sign and magnitude of v1, carried alongside the math
  typedef struct packed {
    logic [15:0] mag;
    logic        neg;
  } side_t;

  typedef struct packed {
    logic [30:0] s;
    side_t       side;
  } item_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  // Uniform sample to signed Q1.15 bits
  function automatic logic [15:0] to_q15(input logic [15:0] u);
    logic [47:0] w;
    logic [15:0] u16;
    w = {32'd0, u} & ((48'd1 << UNIFORM_BITS) - 48'd1);
    if (UNIFORM_BITS >= 16) begin
      w = w >> (UNIFORM_BITS >= 16 ? UNIFORM_BITS - 16 : 0);
    end else begin
      w = w << (UNIFORM_BITS < 16 ? 16 - UNIFORM_BITS : 0);
    end
    u16 = w[15:0];
    return {~u16[15], u16[14:0]};
  endfunction

endpackage

// ----- rtl/core/gps_front.sv -----
// Front end: takes uniform pairs, forms s = v1^2 + v2^2, drops rejects.
// Depends on gps_pkg.
`timescale 1ns / 1ps

module gps_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [15:0]          in_uniform_first,
  input  logic [15:0]          in_uniform_second,
  input  gps_pkg::qstat_t      q_stat,
  output logic                 push,
  output gps_pkg::item_t       push_item
);

  logic                 accept;
  logic [15:0]          v1, v2, m1, m2;
  logic [31:0]          s;
  logic                 keep;
  logic                 push_r;
  gps_pkg::item_t       item_r;

  // Leave room for the item held in the output register
  assign busy   = q_stat.count >= gps_pkg::QCNT_W'(gps_pkg::QUEUE_DEPTH - 1);
  assign accept = start && !busy;

  always_comb begin
    v1   = gps_pkg::to_q15(in_uniform_first);
    v2   = gps_pkg::to_q15(in_uniform_second);
    m1   = v1[15] ? (~v1 + 16'd1) : v1;
    m2   = v2[15] ? (~v2 + 16'd1) : v2;
    s    = 32'({16'd0, m1} * {16'd0, m1}) + 32'({16'd0, m2} * {16'd0, m2});
    keep = (s != 32'd0) && (s <= gps_pkg::ONE_Q30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_r <= 1'b0;
    end else begin
      push_r <= accept && keep;
    end
    item_r.s        <= s[30:0];
    item_r.side.mag <= m1;
    item_r.side.neg <= v1[15];
  end

  assign push      = push_r;
  assign push_item = item_r;

endmodule

// ----- rtl/core/gps_queue.sv -----
// Short FIFO between the front end and the math pipeline.
// Depends on gps_pkg.
`timescale 1ns / 1ps

module gps_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gps_pkg::item_t   push_item,
  input  logic             pop,
  output gps_pkg::item_t   pop_item,
  output gps_pkg::qstat_t  q_stat
);

  gps_pkg::item_t                mem_r [gps_pkg::QUEUE_DEPTH];
  logic [gps_pkg::QPTR_W-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [gps_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign do_pop  = pop && (cnt_r != '0);
  assign do_push = push && (cnt_r != gps_pkg::QCNT_W'(gps_pkg::QUEUE_DEPTH));

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  assign pop_item     = mem_r[rd_r];
  assign q_stat.empty = cnt_r == '0;
  assign q_stat.full  = cnt_r == gps_pkg::QCNT_W'(gps_pkg::QUEUE_DEPTH);
  assign q_stat.count = cnt_r;

endmodule

// ----- rtl/core/gps_back.sv -----
// Math pipeline: log2 by squaring, ln scale, divide, square root, scale.
// One item per cycle; depends on gps_pkg.
`timescale 1ns / 1ps

module gps_back (
  input  logic             clk,
  input  logic             rst_n,
  input  gps_pkg::qstat_t  q_stat,
  input  gps_pkg::item_t   q_item,
  output logic             pop,
  input  logic             truncate_mode,
  input  logic [15:0]      mean_offset,
  input  logic [15:0]      sigma_scale,
  output logic             out_strobe,
  output logic [15:0]      out_gaussian_sample
);

  localparam int LS = gps_pkg::LOG_STEPS;
  localparam int DB = gps_pkg::DIV_BITS;
  localparam int SS = gps_pkg::SQRT_STEPS;

  assign pop = !q_stat.empty;

  // ---- normalize s to m in [1,2) as Q1.30 ----
  logic [4:0]  p, ip;
  always_comb begin
    p = 5'd0;
    for (int b = 0; b < 31; b++) begin
      if (q_item.s[b]) p = 5'(b);
    end
    ip = 5'd30 - p;
  end

  logic           lv_r  [LS+1];
  logic [30:0]    lx_r  [LS+1];
  logic [4:0]     lip_r [LS+1];
  logic [27:0]    lf_r  [LS+1];
  logic [30:0]    ls_r  [LS+1];
  gps_pkg::side_t lsd_r [LS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) lv_r[0] <= 1'b0;
    else        lv_r[0] <= pop;
    lx_r[0]  <= 31'(q_item.s << ip);
    lip_r[0] <= ip;
    lf_r[0]  <= 28'd0;
    ls_r[0]  <= q_item.s;
    lsd_r[0] <= q_item.side;
  end

  // One fraction bit of log2(m) per stage
  for (genvar k = 0; k < LS; k++) begin : g_log
    logic [61:0] sq_nxt;
    logic [31:0] sh_nxt;
    assign sq_nxt = {31'd0, lx_r[k]} * {31'd0, lx_r[k]};
    assign sh_nxt = sq_nxt[61:30];
    always_ff @(posedge clk) begin
      if (!rst_n) lv_r[k+1] <= 1'b0;
      else        lv_r[k+1] <= lv_r[k];
      lx_r[k+1]  <= sh_nxt[31] ? sh_nxt[31:1] : sh_nxt[30:0];
      lf_r[k+1]  <= {lf_r[k][26:0], sh_nxt[31]};
      lip_r[k+1] <= lip_r[k];
      ls_r[k+1]  <= ls_r[k];
      lsd_r[k+1] <= lsd_r[k];
    end
  end

  // ---- -2 ln s = (-log2 s) * ln2 * 2, then into the divider ----
  logic [32:0] nl2;
  logic [62:0] lnp;
  assign nl2 = {lip_r[LS], 28'd0} - {5'd0, lf_r[LS]};
  assign lnp = {30'd0, nl2} * {33'd0, gps_pkg::LN2_Q30};

  logic           dv_r  [DB+1];
  logic [30:0]    drm_r [DB+1];
  logic [63:0]    dd_r  [DB+1];
  logic [63:0]    dq_r  [DB+1];
  logic [30:0]    ds_r  [DB+1];
  gps_pkg::side_t dsd_r [DB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= lv_r[LS];
    drm_r[0] <= 31'd0;
    dd_r[0]  <= {lnp[62:29], 30'd0};
    dq_r[0]  <= 64'd0;
    ds_r[0]  <= ls_r[LS];
    dsd_r[0] <= lsd_r[LS];
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 0; j < DB; j++) begin : g_div
    logic [31:0] t_nxt;
    logic        ge_nxt;
    assign t_nxt  = {drm_r[j], dd_r[j][63]};
    assign ge_nxt = t_nxt >= {1'b0, ds_r[j]};
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j+1] <= 1'b0;
      else        dv_r[j+1] <= dv_r[j];
      drm_r[j+1] <= ge_nxt ? 31'(t_nxt - {1'b0, ds_r[j]}) : t_nxt[30:0];
      dd_r[j+1]  <= {dd_r[j][62:0], 1'b0};
      dq_r[j+1]  <= {dq_r[j][62:0], ge_nxt};
      ds_r[j+1]  <= ds_r[j];
      dsd_r[j+1] <= dsd_r[j];
    end
  end

  // ---- integer square root, one root bit per stage ----
  logic           rv_r  [SS+1];
  logic [31:0]    rt_r  [SS+1];
  logic [33:0]    rr_r  [SS+1];
  logic [63:0]    rx_r  [SS+1];
  gps_pkg::side_t rsd_r [SS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) rv_r[0] <= 1'b0;
    else        rv_r[0] <= dv_r[DB];
    rt_r[0]  <= 32'd0;
    rr_r[0]  <= 34'd0;
    rx_r[0]  <= dq_r[DB];
    rsd_r[0] <= dsd_r[DB];
  end

  for (genvar i = 0; i < SS; i++) begin : g_sqrt
    logic [35:0] t_nxt, trial_nxt;
    logic        ge_nxt;
    assign t_nxt     = {rr_r[i], rx_r[i][63:62]};
    assign trial_nxt = {2'b00, rt_r[i], 2'b01};
    assign ge_nxt    = t_nxt >= trial_nxt;
    always_ff @(posedge clk) begin
      if (!rst_n) rv_r[i+1] <= 1'b0;
      else        rv_r[i+1] <= rv_r[i];
      rr_r[i+1]  <= ge_nxt ? 34'(t_nxt - trial_nxt) : t_nxt[33:0];
      rt_r[i+1]  <= {rt_r[i][30:0], ge_nxt};
      rx_r[i+1]  <= {rx_r[i][61:0], 2'b00};
      rsd_r[i+1] <= rsd_r[i];
    end
  end

  // ---- z magnitude in Q4.12, rounded half up ----
  logic [47:0] zp;
  logic [48:0] zs;
  logic        zv_r, zneg_r;
  logic [31:0] zmag_r;
  assign zp = {32'd0, rsd_r[SS].mag} * {16'd0, rt_r[SS]};
  assign zs = {1'b0, zp} + 49'h1_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) zv_r <= 1'b0;
    else        zv_r <= rv_r[SS];
    zmag_r <= zs[48:17];
    zneg_r <= rsd_r[SS].neg;
  end

  // ---- truncation check and sigma scale ----
  logic        zkeep;
  logic [47:0] pp;
  logic [48:0] ps;
  logic        pv_r, pneg_r;
  logic [36:0] pmag_r;
  assign zkeep = !(truncate_mode && (zmag_r >= gps_pkg::TRUNC_LIMIT_Q12));
  assign pp    = {16'd0, zmag_r} * {32'd0, sigma_scale};
  assign ps    = {1'b0, pp} + 49'd2048;

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else        pv_r <= zv_r && zkeep;
    pmag_r <= ps[48:12];
    pneg_r <= zneg_r;
  end

  // ---- sign, mean, saturate ----
  logic signed [38:0] ymag, ysum;
  logic [15:0]        ysat;
  logic               ov_r;
  logic [15:0]        oy_r;

  always_comb begin
    ymag = signed'({2'b00, pmag_r});
    if (pneg_r) ymag = -ymag;
    ysum = ymag + 39'(signed'(mean_offset));
    if (ysum > 39'sd32767) begin
      ysat = 16'h7FFF;
    end else if (ysum < -39'sd32768) begin
      ysat = 16'h8000;
    end else begin
      ysat = ysum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= pv_r;
    oy_r <= ysat;
  end

  assign out_strobe          = ov_r;
  assign out_gaussian_sample = oy_r;

endmodule

// ----- rtl/core/gaussian_polar_sampler.sv -----
// Top level of the Gaussian polar sampler: config registers, front end,
// queue and math pipeline. Depends on gps_pkg, gps_front, gps_queue, gps_back.
`timescale 1ns / 1ps

// Marsaglia polar-method normal generator. Present one uniform pair per
// cycle on in_uniform_first / in_uniform_second with start; the pair is
// taken when busy is low. The block takes one pair every clock cycle; busy
// only rises if the queue between the front end and the math pipeline
// backs up, which the pipeline prevents since it never stalls. A kept pair
// appears on out_gaussian_sample with out_strobe for one cycle, once it has
// passed the 28 log2 squaring stages, the 64-stage restoring divider and the
// 32-stage square root. A rejected pair (s = 0, s > 1, or |z| at or
// over the bound in truncated mode) gives no strobe at all. The receiver
// cannot stall the output: sample every strobe.
// Write config (index 0 truncate_mode, 1 mean_offset, 2 sigma_scale) only
// while nothing is in flight; cfg_ready is always high.
module gaussian_polar_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_uniform_first,
  input  logic [15:0] in_uniform_second,
  output logic        out_strobe,
  output logic [15:0] out_gaussian_sample,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        trunc_r;
  logic [15:0] mean_r;
  logic [15:0] sigma_r;

  // Config writes are always taken; unknown indexes drop the write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trunc_r <= 1'b0;
      mean_r  <= 16'd0;
      sigma_r <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gps_pkg::cfg_reg_t'(cfg_index))
        gps_pkg::REG_TRUNCATE_MODE: trunc_r <= cfg_data[0];
        gps_pkg::REG_MEAN_OFFSET:   mean_r  <= cfg_data;
        gps_pkg::REG_SIGMA_SCALE:   sigma_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gps_pkg::qstat_t q_stat;
  gps_pkg::item_t  push_item, pop_item;
  logic            push, pop;

  // Front end: map, square, classify
  gps_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_uniform_first  (in_uniform_first),
    .in_uniform_second (in_uniform_second),
    .q_stat            (q_stat),
    .push              (push),
    .push_item         (push_item)
  );

  // Decouple the two halves
  gps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // Back end: log, divide, root, scale
  gps_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .q_item              (pop_item),
    .pop                 (pop),
    .truncate_mode       (trunc_r),
    .mean_offset         (mean_r),
    .sigma_scale         (sigma_r),
    .out_strobe          (out_strobe),
    .out_gaussian_sample (out_gaussian_sample)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue push while full");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  a_not_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !busy)
    else $error("busy with an empty queue");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_stat.empty && !push) |=> (q_stat.count == $past(q_stat.count) - 1'b1))
    else $error("queue did not drain");
`endif

endmodule
